FILE: rtl/mm_pkg.sv
`default_nettype none
package mm_pkg;

  localparam int IDX_W  = 3;
  localparam int DIM_W  = 4;
  localparam int ELEM_W = 16;
  localparam int PROD_W = 32;
  localparam int ACC_W  = 35;

  localparam logic [1:0] KIND_LOAD_A  = 2'd0;
  localparam logic [1:0] KIND_LOAD_B  = 2'd1;
  localparam logic [1:0] KIND_COMPUTE = 2'd2;

  localparam logic [1:0] REG_ROWS_A    = 2'd0;
  localparam logic [1:0] REG_INNER_DIM = 2'd1;
  localparam logic [1:0] REG_COLS_B    = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_PUSH
  } state_t;

  typedef struct packed {
    logic             load;
    logic             issue;
    logic             first;
    logic             fin;
    logic             push;
    logic             push_last;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
    logic [IDX_W-1:0] k;
  } mm_cmd_t;

  typedef struct packed {
    logic done;
    logic out_free;
  } mm_stat_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d,
                                                 input logic [DIM_W-1:0] cap);
    logic [DIM_W-1:0] r;
    r = d;
    if (d == '0) r = DIM_W'(1);
    else if (d > cap) r = cap;
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/matrix_multiplier.sv
`default_nettype none
// Fixed-point matrix multiplier. Load items (tuser = 0 for A, 1 for B) write one
// signed Q8.8 element at row/col. A compute item (tuser = 2) returns every
// element of A x B in row-major order as signed Q19.16, tlast on the final one.
// One shared multiply-accumulate fed by a single read port per store does the
// work: each product element passes through issue, store read, multiply,
// accumulate and hand-off, in that order. in_tready stays low during a run.
// Dimensions are sampled when the compute item is accepted and used saturated
// to 1 .. min(MAX_DIM, 8). Elements must be written before they are used.
module matrix_multiplier #(
  parameter int MAX_DIM = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // row[2:0], col[5:3], value[21:6]
  input  wire logic [1:0]  in_tuser,   // kind[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // out_row[2:0], out_col[5:3], prod_value[40:6]
  output logic             out_tlast,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import mm_pkg::*;

  logic [DIM_W-1:0] rows_a_r, inner_dim_r, cols_b_r;
  logic             cfg_we;
  logic [1:0]       cfg_idx;
  mm_cmd_t          cmd;
  mm_stat_t         stat;
  logic [IDX_W-1:0] out_row, out_col;
  logic [ACC_W-1:0] out_value;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r    <= DIM_W'(8);
      inner_dim_r <= DIM_W'(8);
      cols_b_r    <= DIM_W'(8);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_ROWS_A:    rows_a_r    <= cfg_pwdata[DIM_W-1:0];
        REG_INNER_DIM: inner_dim_r <= cfg_pwdata[DIM_W-1:0];
        REG_COLS_B:    cols_b_r    <= cfg_pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ROWS_A:    cfg_prdata = 32'(rows_a_r);
      REG_INNER_DIM: cfg_prdata = 32'(inner_dim_r);
      REG_COLS_B:    cfg_prdata = 32'(cols_b_r);
      default:       cfg_prdata = '0;
    endcase
  end

  mm_ctrl #(
    .MAX_DIM(MAX_DIM)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_kind   (in_tuser),
    .in_tready (in_tready),
    .rows_a    (rows_a_r),
    .inner_dim (inner_dim_r),
    .cols_b    (cols_b_r),
    .stat      (stat),
    .cmd       (cmd)
  );

  mm_dp #(
    .MAX_DIM(MAX_DIM)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_kind    (in_tuser),
    .in_row     (in_tdata[2:0]),
    .in_col     (in_tdata[5:3]),
    .in_value   (in_tdata[21:6]),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_row    (out_row),
    .out_col    (out_col),
    .out_value  (out_value),
    .out_last   (out_tlast)
  );

  assign out_tdata = {7'b0, out_value, out_col, out_row};

endmodule
`default_nettype wire

FILE: rtl/mm_ctrl.sv
`default_nettype none
module mm_ctrl #(
  parameter int MAX_DIM = 8
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_tvalid,
  input  wire logic [1:0]               in_kind,
  output logic                          in_tready,
  input  wire logic [mm_pkg::DIM_W-1:0] rows_a,
  input  wire logic [mm_pkg::DIM_W-1:0] inner_dim,
  input  wire logic [mm_pkg::DIM_W-1:0] cols_b,
  input  wire mm_pkg::mm_stat_t         stat,
  output mm_pkg::mm_cmd_t               cmd
);
  import mm_pkg::*;

  localparam int DIM_CAP = (MAX_DIM < 8) ? MAX_DIM : 8;

  state_t state_r, state_nxt;
  logic [IDX_W-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [DIM_W-1:0] nr_r, nr_nxt, nk_r, nk_nxt, nc_r, nc_nxt;
  logic start, k_fin, j_fin, i_fin;

  assign start = (state_r == ST_IDLE) && in_tvalid && (in_kind == KIND_COMPUTE);
  assign k_fin = (DIM_W'(k_r) + DIM_W'(1)) == nk_r;
  assign j_fin = (DIM_W'(j_r) + DIM_W'(1)) == nc_r;
  assign i_fin = (DIM_W'(i_r) + DIM_W'(1)) == nr_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (start) state_nxt = ST_ISSUE;
      ST_ISSUE: if (k_fin) state_nxt = ST_WAIT;
      ST_WAIT:  if (stat.done) state_nxt = ST_PUSH;
      ST_PUSH: begin
        if (stat.out_free) state_nxt = (i_fin && j_fin) ? ST_IDLE : ST_ISSUE;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    i_nxt  = i_r;
    j_nxt  = j_r;
    k_nxt  = k_r;
    nr_nxt = nr_r;
    nk_nxt = nk_r;
    nc_nxt = nc_r;
    if (start) begin
      i_nxt  = '0;
      j_nxt  = '0;
      k_nxt  = '0;
      nr_nxt = clamp_dim(rows_a, DIM_W'(DIM_CAP));
      nk_nxt = clamp_dim(inner_dim, DIM_W'(DIM_CAP));
      nc_nxt = clamp_dim(cols_b, DIM_W'(DIM_CAP));
    end else if (state_r == ST_ISSUE) begin
      k_nxt = k_fin ? '0 : k_r + IDX_W'(1);
    end else if (state_r == ST_PUSH && stat.out_free) begin
      j_nxt = j_fin ? '0 : j_r + IDX_W'(1);
      if (j_fin) i_nxt = i_r + IDX_W'(1);
    end
  end

  always_comb begin
    in_tready     = (state_r == ST_IDLE);
    cmd.load      = (state_r == ST_IDLE) && in_tvalid;
    cmd.issue     = (state_r == ST_ISSUE);
    cmd.first     = (k_r == '0);
    cmd.fin       = k_fin;
    cmd.push      = (state_r == ST_PUSH) && stat.out_free;
    cmd.push_last = i_fin && j_fin;
    cmd.i         = i_r;
    cmd.j         = j_r;
    cmd.k         = k_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
      nr_r    <= DIM_W'(1);
      nk_r    <= DIM_W'(1);
      nc_r    <= DIM_W'(1);
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      nr_r    <= nr_nxt;
      nk_r    <= nk_nxt;
      nc_r    <= nc_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/mm_dp.sv
`default_nettype none
module mm_dp #(
  parameter int MAX_DIM = 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [1:0]                in_kind,
  input  wire logic [mm_pkg::IDX_W-1:0]  in_row,
  input  wire logic [mm_pkg::IDX_W-1:0]  in_col,
  input  wire logic [mm_pkg::ELEM_W-1:0] in_value,
  input  wire mm_pkg::mm_cmd_t           cmd,
  output mm_pkg::mm_stat_t               stat,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic [mm_pkg::IDX_W-1:0]       out_row,
  output logic [mm_pkg::IDX_W-1:0]       out_col,
  output logic [mm_pkg::ACC_W-1:0]       out_value,
  output logic                           out_last
);
  import mm_pkg::*;

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);

  function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] r,
                                                  input logic [IDX_W-1:0] c);
    logic [ADDR_W+IDX_W-1:0] full;
    full = (ADDR_W+IDX_W)'(r) * (ADDR_W+IDX_W)'(MAX_DIM) + (ADDR_W+IDX_W)'(c);
    return full[ADDR_W-1:0];
  endfunction

  logic [ELEM_W-1:0] a_mem [DEPTH];
  logic [ELEM_W-1:0] b_mem [DEPTH];
  logic [ELEM_W-1:0] a_rd_r, b_rd_r;
  logic              in_range, a_we, b_we;
  logic [ADDR_W-1:0] w_addr, a_raddr, b_raddr;

  logic                     s1_vld_r, s1_first_r, s1_fin_r;
  logic                     s2_vld_r, s2_first_r, s2_fin_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic                     done_r;

  logic                     ovalid_r;
  logic [IDX_W-1:0]         orow_r, ocol_r;
  logic [ACC_W-1:0]         oval_r;
  logic                     olast_r;

  assign in_range = (int'(in_row) < MAX_DIM) && (int'(in_col) < MAX_DIM);
  assign a_we     = cmd.load && in_range && (in_kind == KIND_LOAD_A);
  assign b_we     = cmd.load && in_range && (in_kind == KIND_LOAD_B);
  assign w_addr   = elem_addr(in_row, in_col);
  assign a_raddr  = elem_addr(cmd.i, cmd.k);
  assign b_raddr  = elem_addr(cmd.k, cmd.j);

  always_ff @(posedge clk) begin
    if (a_we) a_mem[w_addr] <= in_value;
    a_rd_r <= a_mem[a_raddr];
  end

  always_ff @(posedge clk) begin
    if (b_we) b_mem[w_addr] <= in_value;
    b_rd_r <= b_mem[b_raddr];
  end

  always_ff @(posedge clk) begin
    prod_r <= $signed(a_rd_r) * $signed(b_rd_r);
    s1_first_r <= cmd.first;
    s1_fin_r   <= cmd.fin;
    s2_first_r <= s1_first_r;
    s2_fin_r   <= s1_fin_r;
  end

  always_comb begin
    acc_nxt = acc_r;
    if (s2_vld_r) begin
      acc_nxt = (s2_first_r ? '0 : acc_r) + ACC_W'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      s1_vld_r <= cmd.issue;
      s2_vld_r <= s1_vld_r;
      done_r   <= s2_vld_r && s2_fin_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (cmd.push) begin
      ovalid_r <= 1'b1;
    end else if (out_tready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      orow_r  <= cmd.i;
      ocol_r  <= cmd.j;
      oval_r  <= acc_r;
      olast_r <= cmd.push_last;
    end
  end

  assign stat.done     = done_r;
  assign stat.out_free = !ovalid_r || out_tready;
  assign out_tvalid    = ovalid_r;
  assign out_row       = orow_r;
  assign out_col       = ocol_r;
  assign out_value     = oval_r;
  assign out_last      = olast_r;

endmodule
`default_nettype wire

FILE: rtl/mm_checker.sv
`default_nettype none
module mm_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [1:0]  in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [47:0] out_tdata,
  input wire logic        out_tlast,
  input wire logic        cfg_pready
);
  import mm_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_run_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == KIND_COMPUTE) |=> !in_tready)
    else $error("input taken during a compute run");

  a_mid_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input ready before the final result of a run");

  a_pready_high: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("cfg_pready low");

endmodule

bind matrix_multiplier mm_checker u_mm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .cfg_pready (cfg_pready)
);
`default_nettype wire
